[rtl/core/ihdq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval heap queue package
// Shared types and codes for the interval heap double-ended priority queue.
// ----------------------------------------------------------------------------
package ihdq_pkg;

  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] val;
  } entry_t;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_EXT_MIN = 2'd1;
  localparam logic [1:0] OP_EXT_MAX = 2'd2;

  localparam logic [4:0] CMD_NOP         = 5'd0;
  localparam logic [4:0] CMD_LATCH       = 5'd1;
  localparam logic [4:0] CMD_SET_OVF     = 5'd2;
  localparam logic [4:0] CMD_INS_INIT    = 5'd3;
  localparam logic [4:0] CMD_RD_LAST     = 5'd4;
  localparam logic [4:0] CMD_RD_TGT      = 5'd5;
  localparam logic [4:0] CMD_SPEC_GET    = 5'd6;
  localparam logic [4:0] CMD_EXT_GET     = 5'd7;
  localparam logic [4:0] CMD_LAST_GET    = 5'd8;
  localparam logic [4:0] CMD_SIB_RD      = 5'd9;
  localparam logic [4:0] CMD_SIB_SWAP    = 5'd10;
  localparam logic [4:0] CMD_PAR_RD      = 5'd11;
  localparam logic [4:0] CMD_PAR_LO_SWAP = 5'd12;
  localparam logic [4:0] CMD_PAR_HI_RD   = 5'd13;
  localparam logic [4:0] CMD_PAR_HI_SWAP = 5'd14;
  localparam logic [4:0] CMD_CH_RD       = 5'd15;
  localparam logic [4:0] CMD_CH_A        = 5'd16;
  localparam logic [4:0] CMD_CH_B        = 5'd17;
  localparam logic [4:0] CMD_CH_SWAP     = 5'd18;
  localparam logic [4:0] CMD_FIN         = 5'd19;
  localparam logic [4:0] CMD_RD_MIN      = 5'd20;
  localparam logic [4:0] CMD_RD_MAX      = 5'd21;
  localparam logic [4:0] CMD_MAX_GET     = 5'd22;

  typedef struct packed {
    logic is_ins;
    logic is_ext;
    logic full;
    logic empty;
    logic special;
    logic no_sib;
    logic sib_swap;
    logic cur_top;
    logic lo_swap;
    logic hi_swap;
    logic a_none;
    logic b_none;
    logic ch_stop;
  } sts_t;

endpackage

[rtl/core/interval_heap_double_ended_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval heap double-ended priority queue
// Inserts entries and extracts the smallest or largest key, one operation
// at a time, over a heap memory with one read port and one write port.
// ----------------------------------------------------------------------------
// Usage:
//   An operation beat is taken at a rising edge with start high and busy low.
//   operation_i selects insert, extract minimum or extract maximum; the key
//   and value are used by inserts only.
//   Each beat yields exactly one result beat, shown for one cycle with done_o
//   high; the receiver cannot stall it, so it must take it in that cycle.
//   An insert into a full queue, an extract from an empty queue and the
//   unused code skip the sift and go straight to reading back the minimum
//   and maximum. Other operations may walk the heap level by level before
//   that read-back; every compare and swap of the sift loop goes through
//   the one read and one write port of the heap memory.
//   busy stays high from the accepted beat until the result beat, and the
//   next beat is taken in the cycle after it.
//   Reset empties the queue at once; the heap memory needs no clearing pass.
//   An insert into a full queue is dropped and reported with overflow_o.
// ----------------------------------------------------------------------------
module interval_heap_double_ended_queue #(
  parameter int CAPACITY = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    operation_i,
  input  logic signed [31:0]            entry_key_i,
  input  logic signed [31:0]            entry_value_i,
  output logic                          done_o,
  output logic signed [31:0]            extracted_value_o,
  output logic                          extracted_valid_o,
  output logic signed [31:0]            min_value_o,
  output logic signed [31:0]            max_value_o,
  output logic [$clog2(CAPACITY+1)-1:0] entry_count_o,
  output logic                          overflow_o
);
  import ihdq_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  sts_t          sts;
  logic [4:0]    cmd;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, mem_rdata;

  ihdq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  ihdq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .operation_i       (operation_i),
    .entry_key_i       (entry_key_i),
    .entry_value_i     (entry_value_i),
    .mem_we_o          (mem_we),
    .mem_waddr_o       (mem_waddr),
    .mem_wdata_o       (mem_wdata),
    .mem_raddr_o       (mem_raddr),
    .mem_rdata_i       (mem_rdata),
    .extracted_value_o (extracted_value_o),
    .extracted_valid_o (extracted_valid_o),
    .min_value_o       (min_value_o),
    .max_value_o       (max_value_o),
    .entry_count_o     (entry_count_o),
    .overflow_o        (overflow_o)
  );

  ihdq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

[rtl/core/ihdq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ihdq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/ihdq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval heap queue controller
// Sequences the sift steps of each operation and issues datapath commands.
// ----------------------------------------------------------------------------
module ihdq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output logic          done_o,
  input  ihdq_pkg::sts_t sts_i,
  output logic [4:0]    cmd_o
);
  import ihdq_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DEC   = 5'd1;
  localparam logic [4:0] S_SPEC  = 5'd2;
  localparam logic [4:0] S_EXT   = 5'd3;
  localparam logic [4:0] S_LAST  = 5'd4;
  localparam logic [4:0] S_SIB   = 5'd5;
  localparam logic [4:0] S_SIBC  = 5'd6;
  localparam logic [4:0] S_PAR   = 5'd7;
  localparam logic [4:0] S_PLO   = 5'd8;
  localparam logic [4:0] S_PHI   = 5'd9;
  localparam logic [4:0] S_CH    = 5'd10;
  localparam logic [4:0] S_CHA   = 5'd11;
  localparam logic [4:0] S_CHB   = 5'd12;
  localparam logic [4:0] S_CHD   = 5'd13;
  localparam logic [4:0] S_FIN   = 5'd14;
  localparam logic [4:0] S_RDMIN = 5'd15;
  localparam logic [4:0] S_RDMAX = 5'd16;
  localparam logic [4:0] S_MAXG  = 5'd17;
  localparam logic [4:0] S_DONE  = 5'd18;

  logic [4:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NOP;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o   = CMD_LATCH;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (sts_i.is_ins) begin
          if (sts_i.full) begin
            cmd_o   = CMD_SET_OVF;
            state_d = S_RDMIN;
          end else begin
            cmd_o   = CMD_INS_INIT;
            state_d = S_SIB;
          end
        end else if (sts_i.is_ext && !sts_i.empty) begin
          if (sts_i.special) begin
            cmd_o   = CMD_RD_LAST;
            state_d = S_SPEC;
          end else begin
            cmd_o   = CMD_RD_TGT;
            state_d = S_EXT;
          end
        end else begin
          state_d = S_RDMIN;
        end
      end
      S_SPEC: begin
        cmd_o   = CMD_SPEC_GET;
        state_d = S_RDMIN;
      end
      S_EXT: begin
        cmd_o   = CMD_EXT_GET;
        state_d = S_LAST;
      end
      S_LAST: begin
        cmd_o   = CMD_LAST_GET;
        state_d = S_SIB;
      end
      S_SIB: begin
        if (sts_i.no_sib) begin
          state_d = sts_i.is_ins ? S_PAR : S_CH;
        end else begin
          cmd_o   = CMD_SIB_RD;
          state_d = S_SIBC;
        end
      end
      S_SIBC: begin
        if (sts_i.sib_swap) begin
          cmd_o = CMD_SIB_SWAP;
        end
        state_d = sts_i.is_ins ? S_PAR : S_CH;
      end
      S_PAR: begin
        if (sts_i.cur_top) begin
          state_d = S_FIN;
        end else begin
          cmd_o   = CMD_PAR_RD;
          state_d = S_PLO;
        end
      end
      S_PLO: begin
        if (sts_i.lo_swap) begin
          cmd_o   = CMD_PAR_LO_SWAP;
          state_d = S_SIB;
        end else begin
          cmd_o   = CMD_PAR_HI_RD;
          state_d = S_PHI;
        end
      end
      S_PHI: begin
        if (sts_i.hi_swap) begin
          cmd_o   = CMD_PAR_HI_SWAP;
          state_d = S_SIB;
        end else begin
          state_d = S_FIN;
        end
      end
      S_CH: begin
        if (sts_i.a_none) begin
          state_d = S_FIN;
        end else begin
          cmd_o   = CMD_CH_RD;
          state_d = S_CHA;
        end
      end
      S_CHA: begin
        cmd_o   = CMD_CH_A;
        state_d = sts_i.b_none ? S_CHD : S_CHB;
      end
      S_CHB: begin
        cmd_o   = CMD_CH_B;
        state_d = S_CHD;
      end
      S_CHD: begin
        if (sts_i.ch_stop) begin
          state_d = S_FIN;
        end else begin
          cmd_o   = CMD_CH_SWAP;
          state_d = S_SIB;
        end
      end
      S_FIN: begin
        cmd_o   = CMD_FIN;
        state_d = S_RDMIN;
      end
      S_RDMIN: begin
        cmd_o   = CMD_RD_MIN;
        state_d = S_RDMAX;
      end
      S_RDMAX: begin
        cmd_o   = CMD_RD_MAX;
        state_d = S_MAXG;
      end
      S_MAXG: begin
        cmd_o   = CMD_MAX_GET;
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("Result beat not followed by idle.");
  a_start_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == S_DEC)) else $error("Accepted beat not decoded.");
  a_fin_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |=> (state_q == S_RDMIN)) else $error("Final write not followed by read-back.");

endmodule

[rtl/core/ihdq_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval heap queue datapath
// Holds the moving entry, slot indices, count and result registers.
// ----------------------------------------------------------------------------
module ihdq_dp #(
  parameter int CAPACITY = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [4:0]                     cmd_i,
  output ihdq_pkg::sts_t                 sts_o,
  input  logic [1:0]                     operation_i,
  input  logic signed [31:0]             entry_key_i,
  input  logic signed [31:0]             entry_value_i,
  output logic                           mem_we_o,
  output logic [$clog2(CAPACITY)-1:0]    mem_waddr_o,
  output ihdq_pkg::entry_t               mem_wdata_o,
  output logic [$clog2(CAPACITY)-1:0]    mem_raddr_o,
  input  ihdq_pkg::entry_t               mem_rdata_i,
  output logic signed [31:0]             extracted_value_o,
  output logic                           extracted_valid_o,
  output logic signed [31:0]             min_value_o,
  output logic signed [31:0]             max_value_o,
  output logic [$clog2(CAPACITY+1)-1:0]  entry_count_o,
  output logic                           overflow_o
);
  import ihdq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int SW = AW + 2;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [1:0]        op_q;
  entry_t            e_q, e_d, p_q, p_d;
  logic [SW-1:0]     cur_q, cur_d, pick_q, pick_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic signed [31:0] ext_q, ext_d, min_q, min_d, max_q, max_d;
  logic              vld_q, vld_d, ovf_q, ovf_d;

  logic [SW-1:0] lim, sib, tgt, lo, hi, ch_a, ch_b, last;
  logic          one, pick_b;

  assign lim  = SW'(cnt_q) + SW'(2);
  assign last = lim - SW'(1);
  assign sib  = cur_q ^ SW'(1);
  assign tgt  = (op_q == OP_EXT_MAX) ? SW'(3) : SW'(2);
  assign lo   = (cur_q >> 2) << 1;
  assign hi   = lo | SW'(1);
  assign ch_a = cur_q[0] ? (((cur_q - SW'(1)) << 1) | SW'(1)) : (cur_q << 1);
  assign ch_b = cur_q[0] ? ((cur_q << 1) | SW'(1)) : ((cur_q + SW'(1)) << 1);
  assign one  = (cnt_q == CW'(1));
  assign pick_b = cur_q[0] ? (p_q.key < mem_rdata_i.key) : (mem_rdata_i.key < p_q.key);

  always_comb begin
    sts_o.is_ins   = (op_q == OP_INSERT);
    sts_o.is_ext   = (op_q == OP_EXT_MIN) || (op_q == OP_EXT_MAX);
    sts_o.full     = (cnt_q == CW'(CAPACITY));
    sts_o.empty    = (cnt_q == '0);
    sts_o.special  = one || ((cnt_q == CW'(2)) && (op_q == OP_EXT_MAX));
    sts_o.no_sib   = ((cur_q | SW'(1)) >= lim);
    sts_o.sib_swap = cur_q[0] ? (e_q.key < mem_rdata_i.key) : (e_q.key > mem_rdata_i.key);
    sts_o.cur_top  = (cur_q < SW'(4));
    sts_o.lo_swap  = (mem_rdata_i.key > e_q.key);
    sts_o.hi_swap  = (mem_rdata_i.key < e_q.key);
    sts_o.a_none   = (ch_a >= lim);
    sts_o.b_none   = (ch_b >= lim);
    sts_o.ch_stop  = cur_q[0] ? (p_q.key <= e_q.key) : (p_q.key >= e_q.key);
  end

  always_comb begin
    e_d         = e_q;
    p_d         = p_q;
    cur_d       = cur_q;
    pick_d      = pick_q;
    cnt_d       = cnt_q;
    ext_d       = ext_q;
    vld_d       = vld_q;
    ovf_d       = ovf_q;
    min_d       = min_q;
    max_d       = max_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = AW'(cur_q - SW'(2));
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = '0;
    case (cmd_i)
      CMD_LATCH: begin
        e_d   = '{key: entry_key_i, val: entry_value_i};
        ext_d = '0;
        vld_d = 1'b0;
        ovf_d = 1'b0;
      end
      CMD_SET_OVF: begin
        ovf_d = 1'b1;
      end
      CMD_INS_INIT: begin
        cur_d = lim;
        cnt_d = cnt_q + CW'(1);
      end
      CMD_RD_LAST: begin
        mem_raddr_o = AW'(last - SW'(2));
      end
      CMD_RD_TGT: begin
        mem_raddr_o = AW'(tgt - SW'(2));
      end
      CMD_SPEC_GET: begin
        ext_d = mem_rdata_i.val;
        vld_d = 1'b1;
        cnt_d = cnt_q - CW'(1);
      end
      CMD_EXT_GET: begin
        ext_d       = mem_rdata_i.val;
        vld_d       = 1'b1;
        mem_raddr_o = AW'(last - SW'(2));
      end
      CMD_LAST_GET: begin
        e_d   = mem_rdata_i;
        cur_d = tgt;
        cnt_d = cnt_q - CW'(1);
      end
      CMD_SIB_RD: begin
        mem_raddr_o = AW'(sib - SW'(2));
      end
      CMD_SIB_SWAP: begin
        mem_we_o = 1'b1;
        if (op_q == OP_INSERT) begin
          cur_d = sib;
        end else begin
          mem_waddr_o = AW'(sib - SW'(2));
          mem_wdata_o = e_q;
          e_d         = mem_rdata_i;
        end
      end
      CMD_PAR_RD: begin
        mem_raddr_o = AW'(lo - SW'(2));
      end
      CMD_PAR_LO_SWAP: begin
        mem_we_o = 1'b1;
        cur_d    = lo;
      end
      CMD_PAR_HI_RD: begin
        mem_raddr_o = AW'(hi - SW'(2));
      end
      CMD_PAR_HI_SWAP: begin
        mem_we_o = 1'b1;
        cur_d    = hi;
      end
      CMD_CH_RD: begin
        mem_raddr_o = AW'(ch_a - SW'(2));
      end
      CMD_CH_A: begin
        p_d         = mem_rdata_i;
        pick_d      = ch_a;
        mem_raddr_o = AW'(ch_b - SW'(2));
      end
      CMD_CH_B: begin
        if (pick_b) begin
          p_d    = mem_rdata_i;
          pick_d = ch_b;
        end
      end
      CMD_CH_SWAP: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = p_q;
        cur_d       = pick_q;
      end
      CMD_FIN: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = e_q;
      end
      CMD_RD_MIN: begin
        mem_raddr_o = '0;
      end
      CMD_RD_MAX: begin
        min_d       = sts_o.empty ? '0 : mem_rdata_i.val;
        mem_raddr_o = AW'(1);
      end
      CMD_MAX_GET: begin
        max_d = sts_o.empty ? '0 : (one ? min_q : mem_rdata_i.val);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      op_q  <= OP_INSERT;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i == CMD_LATCH) begin
        op_q <= operation_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    e_q    <= e_d;
    p_q    <= p_d;
    cur_q  <= cur_d;
    pick_q <= pick_d;
    ext_q  <= ext_d;
    vld_q  <= vld_d;
    ovf_q  <= ovf_d;
    min_q  <= min_d;
    max_q  <= max_d;
  end

  assign extracted_value_o = ext_q;
  assign extracted_valid_o = vld_q;
  assign min_value_o       = min_q;
  assign max_value_o       = max_q;
  assign entry_count_o     = cnt_q;
  assign overflow_o        = ovf_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY)) else $error("Entry count beyond capacity.");
  a_wr_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (CW'(mem_waddr_o) < cnt_q)) else $error("Write outside occupied slots.");
  a_ovf_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_MAX_GET) |-> !(ovf_q && vld_q)) else $error("Overflow with extraction.");

endmodule
